[hw/rtl/ttg_pkg.sv]
// Package: types, constants and sizes for the triangle tangent generator.
package ttg_pkg;
  localparam int INDEX_BITS_DEF = 16;
  localparam int COMPONENT_BITS_DEF = 16;
  localparam int CB = COMPONENT_BITS_DEF;
  localparam int NORM_FRAC = CB - 2;
  localparam int ROOT_STEPS = 31;
  localparam int DIV_STEPS = NORM_FRAC + 2;

  typedef struct packed {
    logic [15:0] index_c;
    logic [15:0] index_b;
    logic [15:0] index_a;
    logic [47:0] normal_a;
    logic [31:0] uv_c;
    logic [31:0] uv_b;
    logic [31:0] uv_a;
    logic [47:0] pos_c;
    logic [47:0] pos_b;
    logic [47:0] pos_a;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_index_c;
    logic [15:0] out_index_b;
    logic [15:0] out_index_a;
    logic        degenerate;
    logic        handedness_negative;
    logic [47:0] tangent_xyz;
  } out_word_t;

  function automatic logic signed [CB-1:0] comp(input logic [47:0] w, input int i);
    comp = w[i*CB +: CB];
  endfunction
endpackage

[hw/rtl/triangle_tangent_generator.sv]
// Top level: triangle tangent generator with output register.
// Usage: present one triangle word on in_word with in_valid; it is taken at an
// edge where in_valid is high and in_stall is low. Results leave on out_word
// with out_valid; the receiver holds out_stall high to hold the word.
// Pipeline: 57 register stages: seven front stages, a square sum, a 31-stage
// square root, a divider setup and a 16-stage divider, one bit per stage, and
// the output register.
// Throughput: one triangle per cycle while out_stall is low.
// Stall: while the output holds a word, a high out_stall freezes the whole
// pipeline and raises in_stall; nothing is lost or repeated.
// Reset: rst clears all valid bits; the pipeline starts empty.
// A degenerate triangle gives a zero tangent with degenerate set.
// Indices pass alongside the tangent, masked to INDEX_BITS bits (at most 16).
module triangle_tangent_generator import ttg_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);
  logic adv, pv;
  out_word_t pw;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  ttg_pipe #(.INDEX_BITS(INDEX_BITS)) u_pipe (
    .clk, .rst, .adv, .in_valid, .in_word,
    .out_valid(pv), .out_word(pw)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= pv;
    if (adv) out_word <= pw;
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word)) else $error("word lost");
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.degenerate |-> out_word.tangent_xyz == '0) else $error("degen");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("stall");
`endif
endmodule

[hw/rtl/ttg_pipe.sv]
// Pipeline: edges, tangent, normalize shift, square root, division stages.
module ttg_pipe import ttg_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_valid,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);
  typedef struct packed {
    logic        neg;
    logic        degen;
    logic [47:0] idx;
  } side_t;

  // stage 1: deltas
  logic signed [CB:0] e1 [3], e2 [3];
  logic signed [CB:0] d1u, d1v, d2u, d2v;
  logic signed [CB-1:0] n1 [3];
  side_t sd1;
  logic v1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= (CB+1)'(comp(in_word.pos_b, i)) - (CB+1)'(comp(in_word.pos_a, i));
        e2[i] <= (CB+1)'(comp(in_word.pos_c, i)) - (CB+1)'(comp(in_word.pos_a, i));
        n1[i] <= comp(in_word.normal_a, i);
      end
      d1u <= (CB+1)'(comp({16'd0, in_word.uv_b}, 0)) - (CB+1)'(comp({16'd0, in_word.uv_a}, 0));
      d1v <= (CB+1)'(comp({16'd0, in_word.uv_b}, 1)) - (CB+1)'(comp({16'd0, in_word.uv_a}, 1));
      d2u <= (CB+1)'(comp({16'd0, in_word.uv_c}, 0)) - (CB+1)'(comp({16'd0, in_word.uv_a}, 0));
      d2v <= (CB+1)'(comp({16'd0, in_word.uv_c}, 1)) - (CB+1)'(comp({16'd0, in_word.uv_a}, 1));
      sd1.idx <= {in_word.index_c, in_word.index_b, in_word.index_a};
      sd1.neg <= 1'b0;
      sd1.degen <= 1'b0;
    end
  end

  // stage 2: products
  localparam int PW = 2*CB+2;
  logic signed [PW-1:0] pa [3], pb [3], cp [6], dp0, dp1;
  logic signed [CB-1:0] n2 [3];
  side_t sd2;
  logic v2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= PW'(d2v * e1[i]);
        pb[i] <= PW'(d1v * e2[i]);
        n2[i] <= n1[i];
      end
      cp[0] <= PW'(e1[1]*e2[2]); cp[1] <= PW'(e1[2]*e2[1]);
      cp[2] <= PW'(e1[2]*e2[0]); cp[3] <= PW'(e1[0]*e2[2]);
      cp[4] <= PW'(e1[0]*e2[1]); cp[5] <= PW'(e1[1]*e2[0]);
      dp0 <= PW'(d1u * d2v);
      dp1 <= PW'(d2u * d1v);
      sd2 <= sd1;
    end
  end

  // stage 3: differences
  logic signed [PW:0] t3 [3], cr3 [3], det3;
  logic signed [CB-1:0] n3 [3];
  side_t sd3;
  logic v3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t3[i] <= (PW+1)'(pa[i]) - (PW+1)'(pb[i]);
        cr3[i] <= (PW+1)'(cp[2*i]) - (PW+1)'(cp[2*i+1]);
        n3[i] <= n2[i];
      end
      det3 <= (PW+1)'(dp0) - (PW+1)'(dp1);
      sd3 <= sd2;
    end
  end

  // stage 4: dot terms and signed magnitudes
  localparam int DW = PW + CB + 3;
  logic signed [DW-1:0] dt4 [3];
  logic [PW:0] mg4 [3];
  logic [2:0] tn4;
  logic [1:0] sdet4;
  side_t sd4;
  logic v4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [PW:0] tt;
        tt = det3 < 0 ? -t3[i] : t3[i];
        dt4[i] <= DW'(cr3[i] * n3[i]);
        mg4[i] <= tt < 0 ? (PW+1)'(-tt) : (PW+1)'(tt);
        tn4[i] <= tt < 0;
      end
      sdet4 <= det3 > 0 ? 2'b01 : (det3 < 0 ? 2'b11 : 2'b00);
      sd4 <= sd3;
    end
  end

  // stage 5: dot sum, max
  logic [PW:0] mg5 [3], m5;
  logic [2:0] tn5;
  side_t sd5;
  logic v5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
    if (adv) begin
      logic signed [DW-1:0] dsum;
      logic [PW:0] mx;
      logic hpos;
      dsum = dt4[0] + dt4[1] + dt4[2];
      mx = mg4[0] > mg4[1] ? mg4[0] : mg4[1];
      mx = mx > mg4[2] ? mx : mg4[2];
      hpos = (sdet4 == 2'b01 && dsum > 0) || (sdet4 == 2'b11 && dsum < 0);
      mg5 <= mg4; m5 <= mx; tn5 <= tn4;
      sd5.idx <= sd4.idx;
      sd5.neg <= !hpos;
      sd5.degen <= (sdet4 == 2'b00) || (mx == '0);
    end
  end

  // stage 6: leading one of max
  logic [5:0] lz6;
  logic [PW:0] mg6 [3];
  logic [2:0] tn6;
  side_t sd6;
  logic v6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
    if (adv) begin
      logic [5:0] p;
      p = '0;
      for (int b = 0; b <= PW; b++) if (m5[b]) p = 6'(b);
      lz6 <= p;
      mg6 <= mg5; tn6 <= tn5; sd6 <= sd5;
    end
  end

  // stage 7: scale to [2^29,2^30), square
  logic [29:0] mg7 [3];
  logic [59:0] sq7 [3];
  logic [2:0] tn7;
  side_t sd7;
  logic v7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (adv) v7 <= v6;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [63:0] w;
        w = {{(63-PW){1'b0}}, mg6[i]};
        w = lz6 >= 6'd29 ? w >> (lz6 - 6'd29) : w << (6'd29 - lz6);
        mg7[i] <= w[29:0];
        sq7[i] <= 60'(w[29:0]) * 60'(w[29:0]);
      end
      tn7 <= tn6; sd7 <= sd6;
    end
  end

  // stage 8: sum of squares
  logic [61:0] rx [ROOT_STEPS+1];
  logic [31:0] rr [ROOT_STEPS+1];
  logic [29:0] rm [ROOT_STEPS+1][3];
  logic [2:0]  rtn [ROOT_STEPS+1];
  side_t       rsd [ROOT_STEPS+1];
  logic        rv [ROOT_STEPS+1];
  always_ff @(posedge clk) begin
    if (rst) rv[0] <= 1'b0;
    else if (adv) rv[0] <= v7;
    if (adv) begin
      rx[0] <= 62'(sq7[0]) + 62'(sq7[1]) + 62'(sq7[2]);
      rr[0] <= '0; rm[0] <= mg7; rtn[0] <= tn7; rsd[0] <= sd7;
    end
  end

  // root pipeline: one result bit per stage, top bit first
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam int SH = 2*(ROOT_STEPS-1-k);
    always_ff @(posedge clk) begin
      if (rst) rv[k+1] <= 1'b0;
      else if (adv) rv[k+1] <= rv[k];
      if (adv) begin
        logic [63:0] trial;
        trial = (64'(rr[k]) << (SH + 2)) + (64'd1 << SH);
        if (64'(rx[k]) >= trial) begin
          rx[k+1] <= rx[k] - 62'(trial);
          rr[k+1] <= (rr[k] << 1) | 32'd1;
        end else begin
          rx[k+1] <= rx[k];
          rr[k+1] <= rr[k] << 1;
        end
        rm[k+1] <= rm[k]; rtn[k+1] <= rtn[k]; rsd[k+1] <= rsd[k];
      end
    end
  end

  // divider setup: rounded numerator
  localparam int NW = 30 + NORM_FRAC + 1;
  logic [NW-1:0] drem [DIV_STEPS+1][3];
  logic [CB-1:0] dq [DIV_STEPS+1][3];
  logic [31:0]   dr [DIV_STEPS+1];
  logic [2:0]    dtn [DIV_STEPS+1];
  side_t         dsd [DIV_STEPS+1];
  logic          dv [DIV_STEPS+1];
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= rv[ROOT_STEPS];
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (NW'(rm[ROOT_STEPS][i]) << NORM_FRAC) + NW'(rr[ROOT_STEPS] >> 1);
        dq[0][i] <= '0;
      end
      dr[0] <= rr[ROOT_STEPS]; dtn[0] <= rtn[ROOT_STEPS]; dsd[0] <= rsd[ROOT_STEPS];
    end
  end

  // division pipeline: restoring, three lanes, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int J = DIV_STEPS - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) dv[k+1] <= dv[k];
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          logic [NW+1:0] dsub;
          logic [CB-1:0] qn;
          dsub = (NW+2)'(dr[k]) << J;
          qn = dq[k][i];
          if ((NW+2)'(drem[k][i]) >= dsub) begin
            qn[J] = 1'b1;
            drem[k+1][i] <= drem[k][i] - NW'(dsub);
          end else begin
            drem[k+1][i] <= drem[k][i];
          end
          dq[k+1][i] <= qn;
        end
        dr[k+1] <= dr[k]; dtn[k+1] <= dtn[k]; dsd[k+1] <= dsd[k];
      end
    end
  end

  // apply sign, zero degenerate tangents, mask indices
  localparam int IB = INDEX_BITS < 16 ? INDEX_BITS : 16;
  localparam logic [15:0] IMASK = 16'((64'd1 << IB) - 64'd1);
  always_comb begin
    out_valid = dv[DIV_STEPS];
    out_word.out_index_a = dsd[DIV_STEPS].idx[15:0] & IMASK;
    out_word.out_index_b = dsd[DIV_STEPS].idx[31:16] & IMASK;
    out_word.out_index_c = dsd[DIV_STEPS].idx[47:32] & IMASK;
    out_word.handedness_negative = dsd[DIV_STEPS].neg;
    out_word.degenerate = dsd[DIV_STEPS].degen;
    for (int i = 0; i < 3; i++) begin
      logic [CB-1:0] q;
      q = dq[DIV_STEPS][i];
      if (dtn[DIV_STEPS][i]) q = -q;
      out_word.tangent_xyz[i*CB +: CB] = dsd[DIV_STEPS].degen ? '0 : q;
    end
  end
endmodule

[tb/sv/tb_triangle_tangent_generator.sv]
// Testbench for the triangle tangent generator: directed and random triangles, self-checking scoreboard.
module tb_triangle_tangent_generator;
  import ttg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  in_word_t tri_q[$];
  int unsigned gap_q[$];
  bit drain_q[$];
  out_word_t tangent_q[$];

  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit calm;

  triangle_tangent_generator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sx(logic [47:0] w, int i);
    logic signed [15:0] c;
    c = w[i*16 +: 16];
    return longint'(c);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic out_word_t tangent_of(in_word_t w);
    out_word_t o;
    longint e1[3], e2[3], t[3], cr[3], nv[3];
    longint d1u, d1v, d2u, d2v, det, dotp;
    longint unsigned mag[3], m, s, r, q;
    int sdet, sdot;
    bit degen;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = sx(w.pos_b, i) - sx(w.pos_a, i);
      e2[i] = sx(w.pos_c, i) - sx(w.pos_a, i);
      nv[i] = sx(w.normal_a, i);
    end
    d1u = sx(w.uv_b, 0) - sx(w.uv_a, 0);
    d1v = sx(w.uv_b, 1) - sx(w.uv_a, 1);
    d2u = sx(w.uv_c, 0) - sx(w.uv_a, 0);
    d2v = sx(w.uv_c, 1) - sx(w.uv_a, 1);
    det = d1u * d2v - d2u * d1v;
    sdet = det > 0 ? 1 : (det < 0 ? -1 : 0);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    dotp = cr[0] * nv[0] + cr[1] * nv[1] + cr[2] * nv[2];
    sdot = dotp > 0 ? 1 : (dotp < 0 ? -1 : 0);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = d2v * e1[i] - d1v * e2[i];
      if (sdet < 0) t[i] = -t[i];
      mag[i] = t[i] < 0 ? longint'(-t[i]) : longint'(t[i]);
      if (mag[i] > m) m = mag[i];
    end
    degen = (sdet == 0) || (m == 0);
    if (!degen) begin
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      r = root_floor(s);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << NORM_FRAC) + r / 2) / r;
        if (t[i] < 0) q = -q;
        o.tangent_xyz[i*16 +: 16] = q[15:0];
      end
    end
    o.handedness_negative = (sdet * sdot) > 0 ? 1'b0 : 1'b1;
    o.degenerate = degen;
    o.out_index_a = w.index_a;
    o.out_index_b = w.index_b;
    o.out_index_c = w.index_c;
    return o;
  endfunction

  function automatic logic [47:0] v3(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [47:0] r48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] small3(int lim);
    return v3($urandom_range(0, 2*lim) - lim, $urandom_range(0, 2*lim) - lim,
              $urandom_range(0, 2*lim) - lim);
  endfunction

  function automatic logic [31:0] small_uv();
    return {16'($urandom_range(0, 8000) - 4000), 16'($urandom_range(0, 8000) - 4000)};
  endfunction

  task automatic add_tri(in_word_t w, bit drain);
    tri_q.insert(tri_q.size(), w);
    gap_q.insert(gap_q.size(), calm ? 0 : $urandom_range(0, 5));
    drain_q.insert(drain_q.size(), drain);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) tangent_q.insert(tangent_q.size(), tangent_of(in_word));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (tri_q.size() > 0 && !(drain_q[0] && tangent_q.size() > 0)) begin
          in_word <= tri_q.pop_front();
          gap_left <= gap_q.pop_front();
          void'(drain_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        int unsigned h;
        h = calm ? 0 : $urandom_range(0, 5);
        if (tangent_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", out_word);
        end else begin
          out_word_t x;
          x = tangent_q.pop_front();
          if (x.tangent_xyz !== out_word.tangent_xyz ||
              x.handedness_negative !== out_word.handedness_negative ||
              x.degenerate !== out_word.degenerate ||
              x.out_index_a !== out_word.out_index_a ||
              x.out_index_b !== out_word.out_index_b ||
              x.out_index_c !== out_word.out_index_c) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h actual %h", x, out_word);
          end
        end
        hold_left <= h;
        out_stall <= h != 0;
      end else if (hold_left > 0) begin
        out_stall <= hold_left > 1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_word_t w;
    calm = 1'b0;
    w = '0;
    add_tri(w, 1'b0);
    add_tri('1, 1'b0);
    w.pos_a = v3(-32768, -32768, -32768); w.pos_b = v3(32767, 0, 0);
    w.pos_c = v3(0, 32767, 32767); w.uv_a = {16'h8000, 16'h8000};
    w.uv_b = {16'h8000, 16'h7FFF}; w.uv_c = {16'h7FFF, 16'h8000};
    w.normal_a = v3(32767, -32768, 32767);
    w.index_a = 16'hFFFF; w.index_b = 16'h0000; w.index_c = 16'h8001;
    add_tri(w, 1'b0);
    w.uv_c = {16'h7FFF, 16'h7FFF};
    add_tri(w, 1'b0);
    // zero determinant: colinear uvs
    w.pos_b = v3(256, 0, 0); w.pos_c = v3(0, 256, 0);
    w.uv_a = '0; w.uv_b = {16'd100, 16'd100}; w.uv_c = {16'd200, 16'd200};
    add_tri(w, 1'b0);
    // zero tangent with nonzero determinant
    w.pos_a = v3(5, 5, 5); w.pos_b = v3(5, 5, 5); w.pos_c = v3(5, 5, 5);
    w.uv_b = {16'd0, 16'd4096}; w.uv_c = {16'd4096, 16'd0};
    add_tri(w, 1'b0);
    // both determinant signs and both handedness
    for (int k = 0; k < 8; k++) begin
      w.pos_a = v3(0, 0, 0); w.pos_b = v3(256, 0, 0); w.pos_c = v3(0, 256, 0);
      w.uv_a = '0;
      w.uv_b = k[0] ? {16'd0, 16'd4096} : {16'd0, 16'hF000};
      w.uv_c = {16'd4096, 16'd0};
      w.normal_a = k[1] ? v3(0, 0, 16384) : v3(0, 0, -16384);
      if (k[2]) w.normal_a = v3(16384, 0, 0);
      w.index_a = 16'($urandom); w.index_b = 16'($urandom); w.index_c = 16'($urandom);
      add_tri(w, 1'b0);
    end
    for (int k = 0; k < 6; k++) begin
      w.pos_a = r48(); w.pos_b = r48(); w.pos_c = r48();
      w.uv_a = $urandom; w.uv_b = $urandom; w.uv_c = $urandom;
      w.normal_a = r48();
      w.index_a = 16'($urandom); w.index_b = 16'($urandom); w.index_c = 16'($urandom);
      add_tri(w, k == 5);
    end
    for (int k = 0; k < 450; k++) begin
      calm = (k / 60) % 3 == 2;
      w.index_a = 16'($urandom); w.index_b = 16'($urandom); w.index_c = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        w.pos_a = r48(); w.pos_b = r48(); w.pos_c = r48();
        w.uv_a = $urandom; w.uv_b = $urandom; w.uv_c = $urandom;
        w.normal_a = r48();
      end else begin
        w.pos_a = small3(2000); w.pos_b = small3(2000); w.pos_c = small3(2000);
        w.uv_a = small_uv();
        w.uv_b = small_uv();
        w.uv_c = small_uv();
        if ($urandom_range(0, 15) == 0) w.uv_c = w.uv_b;
        w.normal_a = small3(16384);
      end
      add_tri(w, k == 225);
    end
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (tri_q.size() > 0 || in_valid || tangent_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/ttg_pkg.sv
hw/rtl/ttg_pipe.sv
hw/rtl/triangle_tangent_generator.sv
tb/sv/tb_triangle_tangent_generator.sv
